// ===== hw/rtl/plb_pkg.sv =====
`timescale 1ns / 1ps

package plb_pkg;

	// List size and element width.
	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;

	// Fixed field widths on the ports.
	localparam int CMD_W      = 3;
	localparam int POS_W      = 7;
	localparam int IN_VALUE_W = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 6;

	// Internal widths derived from the list size.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_POS   = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Command from the controller to the cell row.
	typedef struct packed {
		logic                   ins;
		logic                   del;
		logic [IDX_W-1:0]       idx;
		logic [VALUE_WIDTH-1:0] value;
	} op_t;

endpackage

// ===== hw/rtl/plb_req_if.sv =====
`timescale 1ns / 1ps

interface plb_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [plb_pkg::CMD_W-1:0]               cmd;
	logic signed [plb_pkg::POS_W-1:0]        position;
	logic [plb_pkg::IN_VALUE_W-1:0]          value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== hw/rtl/plb_rsp_if.sv =====
`timescale 1ns / 1ps

interface plb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [plb_pkg::STATUS_W-1:0]  status;
	logic [plb_pkg::COUNT_W-1:0]   count;

	modport source (output valid, output status, output count, input ready);
	modport sink   (input valid, input status, input count, output ready);
endinterface

// ===== hw/rtl/positional_list_buffer.sv =====
`timescale 1ns / 1ps

// Positional list buffer: an ordered list of up to CAPACITY values with index 0
// at the front. Each request item carries a command (insert front, back or at
// a position; delete front, back or at a position), a position and a value;
// each one yields exactly one response item with a status (done, list empty,
// invalid position, list full) and the element count after the command.
// A positional insert past the end appends at the back; a negative position
// is refused by the positional commands. The list is a row of registers that
// shifts all entries at once: a command is decoded and applied in the cycle it
// is accepted and its response is shown from the next cycle on: one item per
// cycle while the receiver holds ready, the response register letting the
// next request in as the previous response is taken. No clearing pass after reset.

module positional_list_buffer (
	input  logic      clk,
	input  logic      arst_n,
	plb_req_if.sink   req,
	plb_rsp_if.source rsp
);
	import plb_pkg::*;

	op_t              op;
	logic [CNT_W-1:0] count;

	// Controller: handshake, command decode, status, response register.
	plb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.count  (count),
		.op     (op)
	);

	// Datapath: the shifting cell row and the element count.
	plb_cells u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.count  (count)
	);

endmodule

// ===== hw/rtl/plb_ctrl.sv =====
`timescale 1ns / 1ps

module plb_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	plb_req_if.sink                    req,
	plb_rsp_if.source                  rsp,
	input  logic [plb_pkg::CNT_W-1:0]  count,
	output plb_pkg::op_t               op
);
	import plb_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t          state_q;
	status_t         status_q;
	status_t         status_d;
	logic            accept;
	logic            neg;
	logic            full;
	logic            empty;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [CMP_W-1:0] ins_pos;

	assign req.ready = (state_q == S_IDLE) || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign neg     = req.position[POS_W-1];
	assign full    = (count == CNT_W'(CAPACITY));
	assign empty   = (count == '0);
	assign pos_c   = CMP_W'(req.position[POS_W-2:0]);
	assign cnt_c   = CMP_W'(count);
	assign ins_pos = (pos_c < cnt_c) ? pos_c : cnt_c;

	// Decode the command into a status and a cell-row operation.
	always_comb begin
		status_d = ST_DONE;
		op.ins   = 1'b0;
		op.del   = 1'b0;
		op.idx   = '0;
		op.value = VALUE_WIDTH'(req.value);
		case (req.cmd)
			CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
				if (req.cmd == CMD_INS_POS && neg) begin
					status_d = ST_BADPOS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op.ins = accept;
					if (req.cmd == CMD_INS_BACK) op.idx = IDX_W'(count);
					else if (req.cmd == CMD_INS_POS) op.idx = IDX_W'(ins_pos);
				end
			end
			CMD_DEL_FRONT, CMD_DEL_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					op.del = accept;
					if (req.cmd == CMD_DEL_BACK) op.idx = IDX_W'(count - 1'b1);
				end
			end
			CMD_DEL_POS: begin
				if (neg || pos_c >= cnt_c) begin
					status_d = ST_BADPOS;
				end else begin
					op.del = accept;
					op.idx = IDX_W'(pos_c);
				end
			end
			default: status_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_HOLD;
						status_q <= status_d;
					end
				end
				S_HOLD: begin
					if (accept) begin
						status_q <= status_d;
					end else if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid  = (state_q == S_HOLD);
	assign rsp.status = status_q;
	assign rsp.count  = COUNT_W'(count);

endmodule

// ===== hw/rtl/plb_cells.sv =====
`timescale 1ns / 1ps

module plb_cells (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plb_pkg::op_t               op,
	output logic [plb_pkg::CNT_W-1:0]  count
);
	import plb_pkg::*;

	logic [VALUE_WIDTH-1:0] cells_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] prev_w  [CAPACITY];
	logic [VALUE_WIDTH-1:0] next_w  [CAPACITY];
	logic [CNT_W-1:0]       count_q;

	// Neighbor taps; the ends see themselves.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign prev_w[g] = cells_q[g];
		end else begin : g_prev
			assign prev_w[g] = cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_w[g] = cells_q[g];
		end else begin : g_next
			assign next_w[g] = cells_q[g+1];
		end
	end

	// Each cell keeps, loads, shifts back on insert or shifts forward on delete.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (op.ins) begin
				if (IDX_W'(i) == op.idx) cells_q[i] <= op.value;
				else if (IDX_W'(i) > op.idx) cells_q[i] <= prev_w[i];
			end else if (op.del) begin
				if (IDX_W'(i) >= op.idx) cells_q[i] <= next_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.ins) begin
			count_q <= count_q + 1'b1;
		end else if (op.del) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign count = count_q;

endmodule

// ===== hw/rtl/plb_checker.sv =====
`timescale 1ns / 1ps

module plb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [plb_pkg::STATUS_W-1:0]   rsp_status,
	input logic [plb_pkg::COUNT_W-1:0]    rsp_count
);
	import plb_pkg::*;

	// Every accepted item produces a response on the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after accepted item");

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
		else $error("stalled response changed");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");

	// Count moves by at most one between back-to-back responses.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready ##1 rsp_valid |->
			rsp_count == $past(rsp_count) || rsp_count == $past(rsp_count) + 1'b1 ||
			rsp_count == $past(rsp_count) - 1'b1)
		else $error("count jumped");

endmodule

bind positional_list_buffer plb_checker u_plb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import plb_pkg::*;

	// Command codes 6 and 7 are not decoded by the block; they must leave
	// the list alone and answer "done".
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS     = 430;
	localparam int MAX_GAP          = 9;
	localparam int HOLD_OFF_AFTER   = 200;   // responses seen before the long hold-off
	localparam int HOLD_OFF_CYCLES  = 120;
	localparam int DRAIN_CYCLES     = 10;
	localparam int WATCHDOG_LIMIT   = 1500;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [POS_W-1:0] position;
		logic [IN_VALUE_W-1:0]   value;
	} list_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	plb_req_if req_ch ();
	plb_rsp_if rsp_ch ();

	positional_list_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// Commands waiting to be offered, the shadow list, and the responses
	// that the shadow list says must come back, oldest first.
	list_cmd_t                pending_cmd_q[$];
	logic [VALUE_WIDTH-1:0]   shadow_list[$];
	list_rsp_t                expected_rsp_q[$];

	int cmds_sent;
	int rsps_seen;
	int error_count;
	int send_gap;
	int recv_wait;
	int next_wait;
	int idle_cycles;
	int peak_fill;
	int status_hits [4];
	list_rsp_t exp_rsp;

	// Apply one command to the shadow list and return the response the
	// block owes for it. Indexes are 0 at the front.
	function automatic list_rsp_t apply_list_cmd(list_cmd_t c);
		list_rsp_t r;
		int n;
		int p;
		int at;
		n = shadow_list.size();
		p = $signed(c.position);
		r.status = ST_DONE;
		case (c.cmd)
			CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
				// A negative position is refused before fullness is looked at.
				if (c.cmd == CMD_INS_POS && p < 0)
					r.status = ST_BADPOS;
				else if (n >= CAPACITY)
					r.status = ST_FULL;
				else begin
					if (c.cmd == CMD_INS_FRONT)
						at = 0;
					else if (c.cmd == CMD_INS_BACK)
						at = n;
					else
						at = (p > n) ? n : p;   // past the end appends
					shadow_list.insert(at, c.value[VALUE_WIDTH-1:0]);
				end
			end
			CMD_DEL_FRONT: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else
					shadow_list.delete(0);
			end
			CMD_DEL_BACK: begin
				if (n == 0)
					r.status = ST_EMPTY;
				else
					shadow_list.delete(n - 1);
			end
			CMD_DEL_POS: begin
				// Empty list falls under the same rule: no position is below zero.
				if (p < 0 || p >= n)
					r.status = ST_BADPOS;
				else
					shadow_list.delete(p);
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_list.size());
		return r;
	endfunction

	function automatic int draw_gap(bit no_idle);
		return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int pos, logic [31:0] value);
		list_cmd_t c;
		c.cmd      = cmd;
		c.position = POS_W'(pos);
		c.value    = value;
		pending_cmd_q.push_back(c);
	endfunction

	// Request side: offer pending items, hold each one until it is taken,
	// then idle for a drawn number of cycles. Predict on acceptance.
	always @(posedge clk or negedge arst_n) begin
		list_cmd_t nxt;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.cmd      <= '0;
			req_ch.position <= '0;
			req_ch.value    <= '0;
			send_gap        <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				nxt.cmd      = req_ch.cmd;
				nxt.position = req_ch.position;
				nxt.value    = req_ch.value;
				expected_rsp_q.push_back(apply_list_cmd(nxt));
				cmds_sent++;
			end
			if (req_ch.valid && !req_ch.ready) begin
				// hold the offered item
			end else if (send_gap != 0) begin
				req_ch.valid <= 1'b0;
				send_gap     <= send_gap - 1;
			end else if (pending_cmd_q.size() != 0) begin
				nxt = pending_cmd_q.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.cmd      <= nxt.cmd;
				req_ch.position <= nxt.position;
				req_ch.value    <= nxt.value;
				// every third stretch of 64 items goes back to back
				send_gap <= draw_gap(((cmds_sent / 64) % 3) == 1);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response side: check each taken item against the oldest prediction,
	// then drop ready for a drawn number of cycles. Once in the run, hold
	// off for a long stretch so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_wait    <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response status %0d count %0d arrived with nothing expected",
						$time, rsp_ch.status, rsp_ch.count);
					error_count++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp_ch.status !== exp_rsp.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, exp_rsp.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.count !== exp_rsp.count) begin
						$display("%0t: count mismatch, expected %0d, actual %0d",
							$time, exp_rsp.count, rsp_ch.count);
						error_count++;
					end
					status_hits[exp_rsp.status]++;
					if (exp_rsp.count > peak_fill)
						peak_fill = exp_rsp.count;
				end
				rsps_seen++;
				if (rsps_seen == HOLD_OFF_AFTER)
					next_wait = HOLD_OFF_CYCLES;
				else
					next_wait = draw_gap(((rsps_seen / 48) % 3) == 2);
				rsp_ch.ready <= (next_wait == 0);
				recv_wait    <= (next_wait == 0) ? 0 : next_wait - 1;
			end else if (recv_wait != 0) begin
				rsp_ch.ready <= 1'b0;
				recv_wait    <= recv_wait - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d responses outstanding",
				$time, WATCHDOG_LIMIT, expected_rsp_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		list_cmd_t c;
		int seg;
		int ins_pct;
		int roll;

		// Drive reset with a nonblocking write so the async branches see the edge.
		arst_n <= 1'b0;

		// Directed part: empty-list refusals, negative positions, the insert
		// that lands in an empty list, appends past the end, the value
		// extremes, deletes at and past the end, and the spare codes.
		queue_cmd(CMD_DEL_FRONT, 0, 32'h0);
		queue_cmd(CMD_DEL_BACK, 0, 32'h0);
		queue_cmd(CMD_DEL_POS, 0, 32'h0);
		queue_cmd(CMD_INS_POS, 5, 32'h1234_5678);   // empty list: becomes the only element
		queue_cmd(CMD_INS_POS, -1, 32'hFFFF_FFFF);
		queue_cmd(CMD_DEL_POS, -64, 32'h0);
		queue_cmd(CMD_INS_FRONT, 0, 32'h0000_0000);
		queue_cmd(CMD_INS_BACK, 0, 32'hFFFF_FFFF);
		queue_cmd(CMD_INS_POS, 63, 32'hA5A5_A5A5); // far past the end: append
		queue_cmd(CMD_INS_POS, 1, 32'h5A5A_5A5A);
		queue_cmd(CMD_INS_POS, 0, 32'h8000_0001);
		queue_cmd(CMD_DEL_POS, 63, 32'h0);
		queue_cmd(CMD_DEL_POS, 6, 32'h0);          // exactly at count
		queue_cmd(CMD_DEL_POS, 5, 32'h0);          // last element
		queue_cmd(CMD_DEL_POS, 0, 32'h0);
		queue_cmd(CMD_INS_POS, -64, 32'h0);
		queue_cmd(CMD_SPARE_LO, 3, 32'hDEAD_BEEF);
		queue_cmd(CMD_SPARE_HI, -5, 32'hCAFE_F00D);
		queue_cmd(CMD_DEL_FRONT, 0, 32'h0);
		queue_cmd(CMD_DEL_BACK, 0, 32'h0);

		// Random part in stretches of 50: fill, mixed, drain, mixed near full.
		// Filling hard first drives the list into the full refusal.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			seg     = (i / 50) % 4;
			ins_pct = (seg == 0) ? 90 : (seg == 1) ? 50 : (seg == 2) ? 12 : 65;
			roll    = $urandom_range(0, 99);
			if (roll < 3)
				c.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
			else if (roll < 3 + ins_pct * 97 / 100)
				c.cmd = CMD_W'($urandom_range(CMD_INS_FRONT, CMD_INS_POS));
			else
				c.cmd = CMD_W'($urandom_range(CMD_DEL_FRONT, CMD_DEL_POS));
			roll = $urandom_range(0, 9);
			if (roll < 8)
				c.position = POS_W'($urandom_range(0, CAPACITY + 2));
			else if (roll == 8)
				c.position = POS_W'($urandom_range(64, 127));   // negative
			else
				c.position = POS_W'($urandom_range(0, 127));
			c.value = $urandom();
			pending_cmd_q.push_back(c);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every item is taken and every response has come back.
		while (pending_cmd_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_rsp_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
			error_count++;
		end
		$display("Checked %0d responses to %0d commands: done %0d, empty %0d, bad position %0d, full %0d",
			rsps_seen, cmds_sent, status_hits[ST_DONE], status_hits[ST_EMPTY],
			status_hits[ST_BADPOS], status_hits[ST_FULL]);
		$display("Peak fill %0d of %0d cells; one receiver hold-off of %0d cycles",
			peak_fill, CAPACITY, HOLD_OFF_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
